// ----- hdl/fpmi_pkg.sv -----
// shared constants, types and helpers of the 3x3 fixed-point matrix inverse
package fpmi_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DATA_W        = 32;
    localparam int ELEM_N        = 9;
    localparam int LIMIT_W       = 43;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 43'd439804651;
    localparam int PROD_W        = 64;
    localparam int COF_W         = 65;
    localparam int MAG_W         = 64;
    localparam int PART_W        = 65;
    localparam int SUM_W         = 67;
    localparam int DET_W         = 99;
    localparam int DMAG_W        = 96;
    localparam int QUO_W         = 32;
    localparam int REM_W         = DMAG_W + QUO_W;
    localparam int FIFO_DEPTH    = 2;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 64;
    localparam logic REG_LIMIT   = 1'b0;

    typedef struct packed {
        logic [ELEM_N-1:0][REM_W-1:0] num;
        logic [ELEM_N-1:0]            neg;
        logic [DMAG_W-1:0]            dvs;
        logic [DATA_W-1:0]            det;
        logic                         inv;
    } t_work;

    function automatic logic [DATA_W-1:0] sat32(input logic neg, input logic ovf,
                                                input logic [DATA_W-1:0] mag);
        logic [DATA_W-1:0] res;
        if (ovf || mag[DATA_W-1]) begin
            res = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = neg ? (~mag + 1'b1) : mag;
        end
        return res;
    endfunction

endpackage

// ----- hdl/fpmi_if.sv -----
// item channels of the matrix inverse: matrix in, inverse out
interface fpmi_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] in_m00;
    logic signed [31:0] in_m01;
    logic signed [31:0] in_m02;
    logic signed [31:0] in_m10;
    logic signed [31:0] in_m11;
    logic signed [31:0] in_m12;
    logic signed [31:0] in_m20;
    logic signed [31:0] in_m21;
    logic signed [31:0] in_m22;
    modport source (output valid, output in_m00, output in_m01, output in_m02,
                    output in_m10, output in_m11, output in_m12, output in_m20,
                    output in_m21, output in_m22, input ready);
    modport sink (input valid, input in_m00, input in_m01, input in_m02,
                  input in_m10, input in_m11, input in_m12, input in_m20,
                  input in_m21, input in_m22, output ready);
endinterface

interface fpmi_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] inv_m00;
    logic signed [31:0] inv_m01;
    logic signed [31:0] inv_m02;
    logic signed [31:0] inv_m10;
    logic signed [31:0] inv_m11;
    logic signed [31:0] inv_m12;
    logic signed [31:0] inv_m20;
    logic signed [31:0] inv_m21;
    logic signed [31:0] inv_m22;
    logic signed [31:0] det_scaled;
    logic               invertible;
    modport source (output valid, output inv_m00, output inv_m01, output inv_m02,
                    output inv_m10, output inv_m11, output inv_m12, output inv_m20,
                    output inv_m21, output inv_m22, output det_scaled,
                    output invertible, input ready);
    modport sink (input valid, input inv_m00, input inv_m01, input inv_m02,
                  input inv_m10, input inv_m11, input inv_m12, input inv_m20,
                  input inv_m21, input inv_m22, input det_scaled,
                  input invertible, output ready);
endinterface

// ----- hdl/fpmi_front.sv -----
// front pipeline: cofactors, determinant and singular classification
module fpmi_front #(
    parameter int FRAC_BITS = fpmi_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [fpmi_pkg::LIMIT_W-1:0] i_limit,
    fpmi_in_if.sink                      i_mat,
    output logic                         o_valid,
    input  logic                         i_ready,
    output fpmi_pkg::t_work              o_work
);
    import fpmi_pkg::*;

    localparam int SH2 = 2 * FRAC_BITS;

    logic [6:0] r_v;
    logic       en;

    logic [ELEM_N-1:0][DATA_W-1:0] r_m [0:6];
    logic signed [PROD_W-1:0]      r_pa [ELEM_N];
    logic signed [PROD_W-1:0]      r_pb [ELEM_N];
    logic [ELEM_N-1:0][COF_W-1:0]  r_cof [0:3];
    logic signed [PART_W-1:0]      r_ph [3];
    logic signed [PART_W-1:0]      r_pl [3];
    logic signed [SUM_W-1:0]       r_sh;
    logic signed [SUM_W-1:0]       r_sl;
    logic signed [DET_W-1:0]       r_det;
    logic [DMAG_W-1:0]             r_dmag;
    logic                          r_dneg;
    logic [MAG_W-1:0]              r_cabs [ELEM_N];
    logic [ELEM_N-1:0]             r_csgn;

    assign en          = !r_v[6] || i_ready;
    assign i_mat.ready = en;
    assign o_valid     = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:0], i_mat.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        int r1, r2, c1, c2;
        logic [DET_W-1:0] det_abs;
        logic [COF_W-1:0] cof_abs;
        if (en) begin
            r_m[0] <= {i_mat.in_m22, i_mat.in_m21, i_mat.in_m20,
                       i_mat.in_m12, i_mat.in_m11, i_mat.in_m10,
                       i_mat.in_m02, i_mat.in_m01, i_mat.in_m00};
            for (int s = 1; s < 7; s++) begin
                r_m[s] <= r_m[s-1];
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1 = (r + 1) % 3;
                    r2 = (r + 2) % 3;
                    c1 = (c + 1) % 3;
                    c2 = (c + 2) % 3;
                    r_pa[r*3+c] <= $signed(r_m[0][r1*3+c1]) * $signed(r_m[0][r2*3+c2]);
                    r_pb[r*3+c] <= $signed(r_m[0][r1*3+c2]) * $signed(r_m[0][r2*3+c1]);
                end
            end
            for (int k = 0; k < ELEM_N; k++) begin
                r_cof[0][k] <= {r_pa[k][PROD_W-1], r_pa[k]} - {r_pb[k][PROD_W-1], r_pb[k]};
            end
            for (int s = 1; s < 4; s++) begin
                r_cof[s] <= r_cof[s-1];
            end
            for (int c = 0; c < 3; c++) begin
                r_ph[c] <= $signed(r_m[2][c]) * $signed(r_cof[0][c][COF_W-1:32]);
                r_pl[c] <= $signed(r_m[2][c]) * $signed({1'b0, r_cof[0][c][31:0]});
            end
            r_sh  <= r_ph[0] + r_ph[1] + r_ph[2];
            r_sl  <= r_pl[0] + r_pl[1] + r_pl[2];
            r_det <= $signed({r_sh, 32'b0}) + r_sl;
            det_abs = r_det[DET_W-1] ? -r_det : r_det;
            r_dmag <= det_abs[DMAG_W-1:0];
            r_dneg <= r_det[DET_W-1];
            for (int k = 0; k < ELEM_N; k++) begin
                cof_abs = r_cof[3][k][COF_W-1] ? -r_cof[3][k] : r_cof[3][k];
                r_cabs[k] <= cof_abs[MAG_W-1:0];
                r_csgn[k] <= r_cof[3][k][COF_W-1];
            end
        end
    end

    // singular items divide the input magnitude by one
    always_comb begin
        logic              sing;
        logic [DMAG_W-1:0] dsh;
        logic [DATA_W:0]   ma;
        sing = {{(DMAG_W-LIMIT_W){1'b0}}, i_limit} >= r_dmag;
        dsh  = r_dmag >> SH2;
        o_work.dvs = sing ? DMAG_W'(1) : r_dmag;
        o_work.inv = !sing;
        o_work.det = sing ? '0 : sat32(r_dneg, |dsh[DMAG_W-1:DATA_W], dsh[DATA_W-1:0]);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ma = r_m[6][r*3+c][DATA_W-1] ? ({(DATA_W+1){1'b0}} - {1'b1, r_m[6][r*3+c]})
                                             : {1'b0, r_m[6][r*3+c]};
                if (sing) begin
                    o_work.num[r*3+c] = {{(REM_W-DATA_W-1){1'b0}}, ma};
                    o_work.neg[r*3+c] = r_m[6][r*3+c][DATA_W-1];
                end else begin
                    o_work.num[r*3+c] = {{(REM_W-MAG_W){1'b0}}, r_cabs[c*3+r]} << SH2;
                    o_work.neg[r*3+c] = r_csgn[c*3+r] ^ r_dneg;
                end
            end
        end
    end

endmodule

// ----- hdl/fpmi_fifo.sv -----
// two-entry item queue between front and back
module fpmi_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fpmi_pkg::t_work i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output fpmi_pkg::t_work o_data
);
    import fpmi_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_work            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = r_cnt != CNT_W'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hdl/fpmi_back.sv -----
// back pipeline: nine-lane restoring divider with saturation
module fpmi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fpmi_pkg::t_work i_work,
    fpmi_out_if.source      o_inv
);
    import fpmi_pkg::*;

    localparam int NS = QUO_W + 2;

    typedef struct packed {
        logic [ELEM_N-1:0][REM_W-1:0] rem;
        logic [ELEM_N-1:0][QUO_W-1:0] quo;
        logic [ELEM_N-1:0]            ovf;
        logic [ELEM_N-1:0]            neg;
        logic [DMAG_W-1:0]            dvs;
        logic [DATA_W-1:0]            det;
        logic                         inv;
    } t_div;

    t_div              r_st [0:NS-1];
    t_div              n_st [1:NS-1];
    logic [NS-1:0]     r_v;
    logic              r_ov;
    logic [DATA_W-1:0] r_res [ELEM_N];
    logic [DATA_W-1:0] r_det;
    logic              r_inv;
    logic              en;

    assign en      = !r_ov || o_inv.ready;
    assign o_ready = en;

    genvar j;
    generate
        for (j = 0; j < NS - 1; j++) begin : g_stage
            if (j == 0) begin : g_ovf
                always_comb begin
                    logic [REM_W-1:0] dsh;
                    n_st[j+1] = r_st[j];
                    dsh = {r_st[j].dvs, {QUO_W{1'b0}}};
                    for (int k = 0; k < ELEM_N; k++) begin
                        n_st[j+1].ovf[k] = r_st[j].rem[k] >= dsh;
                    end
                end
            end else begin : g_div
                always_comb begin
                    logic [REM_W-1:0] dsh;
                    n_st[j+1] = r_st[j];
                    dsh = {{QUO_W{1'b0}}, r_st[j].dvs} << (QUO_W - j);
                    for (int k = 0; k < ELEM_N; k++) begin
                        if (r_st[j].rem[k] >= dsh) begin
                            n_st[j+1].rem[k]            = r_st[j].rem[k] - dsh;
                            n_st[j+1].quo[k][QUO_W - j] = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_st[j+1] <= n_st[j+1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0].rem <= i_work.num;
            r_st[0].quo <= '0;
            r_st[0].ovf <= '0;
            r_st[0].neg <= i_work.neg;
            r_st[0].dvs <= i_work.dvs;
            r_st[0].det <= i_work.det;
            r_st[0].inv <= i_work.inv;
            for (int k = 0; k < ELEM_N; k++) begin
                r_res[k] <= sat32(r_st[NS-1].neg[k], r_st[NS-1].ovf[k], r_st[NS-1].quo[k]);
            end
            r_det <= r_st[NS-1].det;
            r_inv <= r_st[NS-1].inv;
        end
    end

    assign o_inv.valid      = r_ov;
    assign o_inv.inv_m00    = r_res[0];
    assign o_inv.inv_m01    = r_res[1];
    assign o_inv.inv_m02    = r_res[2];
    assign o_inv.inv_m10    = r_res[3];
    assign o_inv.inv_m11    = r_res[4];
    assign o_inv.inv_m12    = r_res[5];
    assign o_inv.inv_m20    = r_res[6];
    assign o_inv.inv_m21    = r_res[7];
    assign o_inv.inv_m22    = r_res[8];
    assign o_inv.det_scaled = r_det;
    assign o_inv.invertible = r_inv;

endmodule

// ----- hdl/fixed_point_matrix3_inverse_top.sv -----
// top level of the 3x3 fixed-point matrix inverse with its register port
// Takes one 3x3 matrix per cycle unless stalled and returns its inverse (adjugate over
// determinant, truncated toward zero, saturated to 32 bits), the determinant
// at scale 2^FRAC_BITS and an invertible flag; a matrix whose determinant
// magnitude is at or below singular_limit comes back unchanged with flag 0.
// With no stalls a matrix passes 7 front stages for products, cofactors,
// determinant and classification, the 2-entry queue, 34 divider stages
// (input, overflow check, then one quotient bit per stage in nine lanes)
// and the output register. A held result stalls the divider, and the queue
// lets the front run on for two more items. singular_limit sits at address 0;
// the user must write it only while the block is idle; the block does not enforce this.
module fixed_point_matrix3_inverse_top #(
    parameter int FRAC_BITS = fpmi_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fpmi_in_if.sink                         i_mat,
    fpmi_out_if.source                      o_inv,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpmi_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fpmi_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fpmi_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import fpmi_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               f_valid;
    logic               f_ready;
    t_work              f_work;
    logic               b_valid;
    logic               b_ready;
    t_work              b_work;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_LIMIT) ? {{(CFG_DATA_W-LIMIT_W){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[3] == REG_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    fpmi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_limit),
        .i_mat   (i_mat),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_work  (f_work)
    );

    fpmi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_work),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (b_work)
    );

    fpmi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .o_ready (b_ready),
        .i_work  (b_work),
        .o_inv   (o_inv)
    );

endmodule

// ----- bench/tb.sv -----
// self-checking testbench of the 3x3 fixed-point matrix inverse
`timescale 1ns / 1ps

typedef logic signed [31:0] elem9_t [9];

typedef struct {
    elem9_t             inv;
    logic signed [31:0] det;
    logic               ok;
} inv_res_t;

class inverse_board;
    localparam int SHIFT = 2 * fpmi_pkg::FRAC_BITS_DEF;
    logic [42:0] singular_limit;
    inv_res_t    pending[$];
    int          errors;

    function new();
        singular_limit = fpmi_pkg::LIMIT_RESET;
        errors = 0;
    endfunction

    function logic signed [31:0] clamp32(logic neg, logic [127:0] mag);
        logic signed [31:0] r;
        if (!neg) begin
            r = (mag > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
        end else begin
            r = (mag >= 128'h8000_0000) ? 32'sh8000_0000 : -mag[31:0];
        end
        return r;
    endfunction

    function void note_matrix(elem9_t m);
        logic signed [127:0] a [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] d;
        logic [127:0] dmag, amag, q;
        inv_res_t e;
        int r1, r2, c1, c2;
        for (int i = 0; i < 9; i++) a[i] = m[i];
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r1 = (r + 1) % 3; r2 = (r + 2) % 3;
                c1 = (c + 1) % 3; c2 = (c + 2) % 3;
                cof[r*3+c] = a[r1*3+c1] * a[r2*3+c2] - a[r1*3+c2] * a[r2*3+c1];
            end
        end
        d = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
        dmag = (d < 0) ? -d : d;
        if (dmag <= {85'd0, singular_limit}) begin
            e.inv = m;
            e.det = 0;
            e.ok  = 0;
        end else begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    amag = (cof[c*3+r] < 0) ? -cof[c*3+r] : cof[c*3+r];
                    q = (amag << SHIFT) / dmag;
                    e.inv[r*3+c] = clamp32((cof[c*3+r] < 0) != (d < 0), q);
                end
            end
            e.det = clamp32(d < 0, dmag >> SHIFT);
            e.ok  = 1;
        end
        pending.push_back(e);
    endfunction

    function void check_result(inv_res_t got);
        inv_res_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result item", $time);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 9; i++) begin
            if (got.inv[i] !== e.inv[i]) begin
                $display("%0t: inv_m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                         e.inv[i], got.inv[i]);
                errors++;
            end
        end
        if (got.det !== e.det) begin
            $display("%0t: det_scaled expected %0d actual %0d", $time, e.det, got.det);
            errors++;
        end
        if (got.ok !== e.ok) begin
            $display("%0t: invertible expected %0b actual %0b", $time, e.ok, got.ok);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int ONE = 1 << fpmi_pkg::FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [fpmi_pkg::CFG_ADDR_W-1:0] paddr;
    logic [fpmi_pkg::CFG_DATA_W-1:0] pwdata, prdata;
    logic        calm;
    int          cycles;
    inverse_board board;

    fpmi_in_if  mat_if();
    fpmi_out_if inv_if();

    fixed_point_matrix3_inverse_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_if),
        .o_inv   (inv_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[fixed_point_matrix3_inverse_top] ERROR");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic put_matrix(elem9_t m);
        mat_if.in_m00 = m[0]; mat_if.in_m01 = m[1]; mat_if.in_m02 = m[2];
        mat_if.in_m10 = m[3]; mat_if.in_m11 = m[4]; mat_if.in_m12 = m[5];
        mat_if.in_m20 = m[6]; mat_if.in_m21 = m[7]; mat_if.in_m22 = m[8];
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_matrix(elem9_t m);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            mat_if.valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        mat_if.valid = 1;
        put_matrix(m);
        do @(posedge i_clk); while (!mat_if.ready);
        board.note_matrix(m);
        @(negedge i_clk);
    endtask

    initial begin
        inv_res_t got;
        int gap;
        inv_if.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                inv_if.ready = 0;
                repeat (gap) @(negedge i_clk);
            end
            inv_if.ready = 1;
            do @(posedge i_clk); while (!inv_if.valid);
            got.inv[0] = inv_if.inv_m00; got.inv[1] = inv_if.inv_m01;
            got.inv[2] = inv_if.inv_m02; got.inv[3] = inv_if.inv_m10;
            got.inv[4] = inv_if.inv_m11; got.inv[5] = inv_if.inv_m12;
            got.inv[6] = inv_if.inv_m20; got.inv[7] = inv_if.inv_m21;
            got.inv[8] = inv_if.inv_m22;
            got.det = inv_if.det_scaled;
            got.ok  = inv_if.invertible;
            board.check_result(got);
        end
    end

    task automatic drain();
        mat_if.valid = 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [42:0] value);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {fpmi_pkg::REG_LIMIT, 3'b000};
        pwdata = {21'd0, value};
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        board.singular_limit = value;
    endtask

    function automatic elem9_t diag3(int a, int b, int c);
        elem9_t m;
        m = '{a, 0, 0, 0, b, 0, 0, 0, c};
        return m;
    endfunction

    // 2x2 block with determinant -1, so the whole determinant is -z
    function automatic elem9_t tiny_det(int z);
        elem9_t m;
        m = '{32'sh4000_0000, 32'sh3FFF_FFFF, 0,
              32'sh3FFF_FFFF, 32'sh3FFF_FFFE, 0, 0, 0, z};
        return m;
    endfunction

    function automatic elem9_t random_matrix();
        elem9_t m;
        int kind, span;
        kind = $urandom_range(0, 9);
        span = $urandom_range(1, 4) * ONE;
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0, 1:    m[i] = $urandom;
                2, 3, 4: m[i] = $signed($urandom_range(0, 2 * span)) - span;
                default: m[i] = $signed($urandom_range(0, 2 * ONE)) - ONE;
            endcase
        end
        if (kind >= 5 && kind <= 7) begin
            for (int i = 0; i < 3; i++)
                m[i*4] = m[i*4] + ($urandom_range(0, 1) ? 4 * ONE : -4 * ONE);
        end else if (kind == 8) begin
            for (int i = 0; i < 3; i++) m[6+i] = m[i];
        end else if (kind == 9) begin
            m = tiny_det($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000));
        end
        return m;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            send_matrix(random_matrix());
        end
        calm = 0;
    endtask

    initial begin
        elem9_t directed [$];
        i_rst_n = 0;
        calm = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        mat_if.valid = 0;
        put_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        board = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        directed.push_back(diag3(ONE, ONE, ONE));
        directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back(diag3(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        directed.push_back(diag3(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        directed.push_back(diag3(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        directed.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                             32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        directed.push_back('{32'sh8000_0000, 1, 2, 3, 32'sh8000_0000, 5, 7, 11,
                             32'sh7FFF_FFFF});
        directed.push_back(diag3(1, 1, 439804651));
        directed.push_back(diag3(1, 1, 439804652));
        directed.push_back(diag3(-1, 1, 439804652));
        directed.push_back(diag3(1 << 10, 1 << 10, 1 << 10));
        directed.push_back(diag3(1 << 8, 1 << 8, 1 << 8));
        directed.push_back(diag3(2 * ONE, -ONE / 2, 3 * ONE));
        directed.push_back('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
        directed.push_back('{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 0, 0, ONE});
        directed.push_back('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                             7 * ONE, 8 * ONE, 9 * ONE});
        directed.push_back(tiny_det(1 << 30));
        directed.push_back(tiny_det(-(1 << 30)));
        directed.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
        foreach (directed[i]) send_matrix(directed[i]);
        random_phase(140);
        drain();

        write_limit(43'd0);
        send_matrix(tiny_det(1));
        send_matrix(tiny_det(0));
        send_matrix(tiny_det(-1));
        random_phase(130);
        drain();

        write_limit(43'h400_0000_0000);
        send_matrix(diag3(32'sh4000_0000, 1 << 12, 1));
        send_matrix(diag3(32'sh4000_0000, 1 << 12, 2));
        random_phase(130);
        drain();

        write_limit(43'({$urandom_range(0, 1023), $urandom}));
        random_phase(130);
        drain();

        if (board.errors == 0) begin
            $display("[fixed_point_matrix3_inverse_top] OK");
        end else begin
            $display("[fixed_point_matrix3_inverse_top] ERROR");
        end
        $finish;
    end
endmodule
